/* design/nmea_sentence_deframer_assert.svh */
// Assertion macros shared by the sentence deframer checker.
`ifndef NMEA_SENTENCE_DEFRAMER_ASSERT_SVH
`define NMEA_SENTENCE_DEFRAMER_ASSERT_SVH

// Checked at every rising edge, suspended while reset is asserted.
`define NSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define NSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/nsd_pkg.sv */
// Types and constants of the NMEA sentence deframer.
package nsd_pkg;

    // Character codes.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    // Sentence identifiers as packed character strings.
    localparam logic [23:0] ID_RMC   = 24'h524D43;
    localparam logic [23:0] ID_GGA   = 24'h474741;
    localparam logic [23:0] ID_GSA   = 24'h475341;
    localparam logic [39:0] ID_GPTXT = 40'h4750545854;
    localparam logic [31:0] ID_PROP  = 32'h504D544B;

    // Sentence kind codes.
    localparam logic [2:0] KIND_UNKNOWN     = 3'd0;
    localparam logic [2:0] KIND_RMC         = 3'd1;
    localparam logic [2:0] KIND_GGA         = 3'd2;
    localparam logic [2:0] KIND_GSA         = 3'd3;
    localparam logic [2:0] KIND_GPTXT       = 3'd4;
    localparam logic [2:0] KIND_PROPRIETARY = 3'd5;

    // Configuration register indexes.
    localparam int unsigned REG_STRICT_CHECKSUM = 0;
    localparam int unsigned REG_COUNT           = 1;

    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [2:0] sentence_kind;
        logic       checksum_ok;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
        logic [9:0] payload_length;
    } t_out_item;

    // An input item after classification.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       flush;
        logic       is_newline;
        logic       is_dollar;
        logic       is_star;
        logic       is_hex;
        logic [3:0] hex_digit;
    } t_front_item;

endpackage

/* design/nmea_sentence_deframer.sv */
// Top level of the NMEA sentence deframer: front end, queue, back end and config register.
//
// Serial bytes enter as items one per cycle while the input is not stalled; a flush item
// drops the partial line. Each newline that closes a line holding a dollar, a later star
// and at least one byte after that star gives one result item: sentence kind, computed
// and received checksums, match flag and payload length. The sustained rate is one byte
// per cycle while the output is not stalled, set by the back end's state update, which
// settles the running XOR, the counters and the hex digit of a byte. An accepted newline
// passes through the two-entry queue and, when the back end takes it, closes its result
// item into the output register. The input stalls only when the queue is full, which
// happens only after the output has been stalled. Register 0 at byte address 0, bit 0,
// is strict_checksum: when set, sentences with a bad checksum give no result.
module nmea_sentence_deframer #(
    parameter int unsigned LINE_BUFFER_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nsd_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nsd_pkg::t_out_item o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import nsd_pkg::*;

    t_front_item front_item;
    t_front_item q_item;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        pop;
    logic        r_strict;
    logic        reg_hit;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_hit = (32'(paddr[2]) == REG_STRICT_CHECKSUM) && (32'(paddr[2]) < REG_COUNT);
    assign prdata  = reg_hit ? {31'b0, r_strict} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_strict <= pwdata[0];
        end
    end

    nsd_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_queue_full (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_item       (front_item)
    );

    nsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    nsd_back #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_strict    (r_strict),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* design/nsd_front.sv */
// Front end: takes input items and classifies each received byte.
module nsd_front (
    input  logic                i_in_valid,
    input  nsd_pkg::t_in_item   i_in_item,
    input  logic                i_queue_full,
    output logic                o_in_stall,
    output logic                o_push,
    output nsd_pkg::t_front_item o_item
);
    import nsd_pkg::*;

    logic [7:0] b;

    assign b          = i_in_item.rx_byte;
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Character class and hex digit value.
    always_comb begin
        o_item            = '0;
        o_item.rx_byte    = b;
        o_item.flush      = i_in_item.flush;
        o_item.is_newline = (b == CH_NEWLINE);
        o_item.is_dollar  = (b == CH_DOLLAR);
        o_item.is_star    = (b == CH_STAR);
        if (b >= 8'h30 && b <= 8'h39) begin
            o_item.is_hex    = 1'b1;
            o_item.hex_digit = b[3:0];
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            o_item.is_hex    = 1'b1;
            o_item.hex_digit = b[3:0] + 4'd9;
        end
    end

endmodule

/* design/nsd_queue.sv */
// Short queue of classified items between front and back.
module nsd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  nsd_pkg::t_front_item i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output nsd_pkg::t_front_item o_item
);
    import nsd_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_front_item r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    // Pointer and fill count updates.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* design/nsd_back.sv */
// Back end: line state, checksum, sentence kind and the output register.
module nsd_back #(
    parameter int unsigned LINE_BUFFER_BYTES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_strict,
    input  logic                 i_q_valid,
    input  nsd_pkg::t_front_item i_q_item,
    output logic                 o_pop,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output nsd_pkg::t_out_item   o_out_item
);
    import nsd_pkg::*;

    localparam int unsigned LW = $clog2(LINE_BUFFER_BYTES + 1);
    localparam int unsigned BW = $clog2(LINE_BUFFER_BYTES);
    localparam int unsigned EW = (BW > 10) ? BW : 10;

    logic [LW-1:0] r_line, n_line;
    logic          r_dollar, n_dollar;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_xor_star, n_xor_star;
    logic          r_star, n_star;
    logic [1:0]    r_after, n_after;
    logic [7:0]    r_hex, n_hex;
    logic          r_hex_stop, n_hex_stop;
    logic [7:0]    r_id [5];
    logic [7:0]    n_id [5];
    logic [BW-1:0] r_body, n_body;
    logic [BW-1:0] r_body_star, n_body_star;

    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          emit;
    logic          ok;
    logic [2:0]    kind;
    logic [EW-1:0] len_ext;
    logic [9:0]    len;
    t_front_item   it;

    assign it          = i_q_item;
    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Sentence kind from the first five payload bytes, first match wins.
    always_comb begin
        kind = KIND_UNKNOWN;
        if (r_body_star >= BW'(5) && {r_id[2], r_id[3], r_id[4]} == ID_RMC) begin
            kind = KIND_RMC;
        end else if (r_body_star >= BW'(5) && {r_id[2], r_id[3], r_id[4]} == ID_GGA) begin
            kind = KIND_GGA;
        end else if (r_body_star >= BW'(5) && {r_id[2], r_id[3], r_id[4]} == ID_GSA) begin
            kind = KIND_GSA;
        end else if (r_body_star >= BW'(5)
                     && {r_id[0], r_id[1], r_id[2], r_id[3], r_id[4]} == ID_GPTXT) begin
            kind = KIND_GPTXT;
        end else if (r_body_star >= BW'(4) && {r_id[0], r_id[1], r_id[2], r_id[3]} == ID_PROP) begin
            kind = KIND_PROPRIETARY;
        end
    end

    // Payload length saturates at the width of the output field.
    assign len_ext = EW'(r_body_star);
    assign len     = (len_ext > EW'(1023)) ? 10'd1023 : len_ext[9:0];
    assign ok      = (r_xor_star == r_hex);

    // Per-byte update of the line state.
    always_comb begin
        n_line      = r_line;
        n_dollar    = r_dollar;
        n_xor       = r_xor;
        n_xor_star  = r_xor_star;
        n_star      = r_star;
        n_after     = r_after;
        n_hex       = r_hex;
        n_hex_stop  = r_hex_stop;
        n_id        = r_id;
        n_body      = r_body;
        n_body_star = r_body_star;
        emit        = 1'b0;

        if (it.flush || it.is_newline) begin
            // A newline closes the line; a sentence is complete only with a
            // dollar, a later star and at least one byte after that star.
            emit = !it.flush && it.is_newline && r_dollar && r_star && (r_after != 2'd0)
                   && (ok || !i_strict);
            n_line      = '0;
            n_dollar    = 1'b0;
            n_xor       = '0;
            n_xor_star  = '0;
            n_star      = 1'b0;
            n_after     = '0;
            n_hex       = '0;
            n_hex_stop  = 1'b0;
            n_body      = '0;
            n_body_star = '0;
            for (int i = 0; i < 5; i++) begin
                n_id[i] = '0;
            end
        end else if (r_line + 1'b1 >= LW'(LINE_BUFFER_BYTES)) begin
            // Line buffer full without a newline: drop the line.
            n_line      = '0;
            n_dollar    = 1'b0;
            n_xor       = '0;
            n_xor_star  = '0;
            n_star      = 1'b0;
            n_after     = '0;
            n_hex       = '0;
            n_hex_stop  = 1'b0;
            n_body      = '0;
            n_body_star = '0;
            for (int i = 0; i < 5; i++) begin
                n_id[i] = '0;
            end
        end else if (!r_dollar) begin
            n_line = r_line + 1'b1;
            if (it.is_dollar) begin
                n_dollar = 1'b1;
                n_xor    = '0;
                n_body   = '0;
                n_star   = 1'b0;
            end
        end else begin
            n_line = r_line + 1'b1;
            if (it.is_star) begin
                n_star      = 1'b1;
                n_xor_star  = r_xor;
                n_body_star = r_body;
                n_after     = '0;
                n_hex       = '0;
                n_hex_stop  = 1'b0;
            end else if (r_star) begin
                if (r_after < 2'd2 && !r_hex_stop) begin
                    if (it.is_hex) begin
                        n_hex = {r_hex[3:0], it.hex_digit};
                    end else begin
                        n_hex_stop = 1'b1;
                    end
                end
                if (r_after != 2'd3) begin
                    n_after = r_after + 2'd1;
                end
            end
            for (int i = 0; i < 5; i++) begin
                if (r_body == BW'(i)) begin
                    n_id[i] = it.rx_byte;
                end
            end
            n_xor  = r_xor ^ it.rx_byte;
            n_body = r_body + 1'b1;
        end
    end

    // Line state registers advance on each item taken from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_dollar    <= 1'b0;
            r_xor       <= '0;
            r_xor_star  <= '0;
            r_star      <= 1'b0;
            r_after     <= '0;
            r_hex       <= '0;
            r_hex_stop  <= 1'b0;
            r_body      <= '0;
            r_body_star <= '0;
            for (int i = 0; i < 5; i++) begin
                r_id[i] <= '0;
            end
        end else if (o_pop) begin
            r_line      <= n_line;
            r_dollar    <= n_dollar;
            r_xor       <= n_xor;
            r_xor_star  <= n_xor_star;
            r_star      <= n_star;
            r_after     <= n_after;
            r_hex       <= n_hex;
            r_hex_stop  <= n_hex_stop;
            r_body      <= n_body;
            r_body_star <= n_body_star;
            r_id        <= n_id;
        end
    end

    // Output register holds a result item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_item.sentence_kind     <= kind;
            r_out_item.checksum_ok       <= ok;
            r_out_item.computed_checksum <= r_xor_star;
            r_out_item.received_checksum <= r_hex;
            r_out_item.payload_length    <= len;
        end
    end

endmodule

/* design/nsd_checker.sv */
// Port-level checker for the sentence deframer and its bind statement.
`include "nmea_sentence_deframer_assert.svh"

module nsd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input nsd_pkg::t_out_item o_out_item
);
    import nsd_pkg::*;

    logic out_held;
    logic ok_agrees;
    logic kind_valid;

    // Views of the result item that the assertions below look at.
    assign out_held   = o_out_valid && i_out_stall;
    assign ok_agrees  = (o_out_item.checksum_ok
                         == (o_out_item.computed_checksum == o_out_item.received_checksum));
    assign kind_valid = (o_out_item.sentence_kind <= KIND_PROPRIETARY);

    // The output register was free in the previous cycle and is free now.
    property p_no_stall_free;
        !o_out_valid && !$past(o_out_valid) && !$past(i_out_stall) |-> !o_in_stall;
    endproperty

    // Reset empties the output register.
    `NSD_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A stalled result item holds.
    `NSD_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(o_out_item), "stalled item changed")

    // The match flag agrees with the two checksums carried.
    `NSD_ASSERT(a_ok_flag, o_out_valid |-> ok_agrees, "checksum flag mismatch")

    // Only defined sentence kinds are reported.
    `NSD_ASSERT(a_kind_range, o_out_valid |-> kind_valid, "bad sentence kind")

    // The input never stalls while the output side drains freely.
    `NSD_ASSERT(a_no_stall_free, p_no_stall_free, "input stalled with free output")

endmodule

bind nmea_sentence_deframer nsd_checker u_nsd_checker (.*);

/* sim/nmea_sentence_deframer_test.sv */
// Self-checking testbench for the NMEA sentence deframer: byte stream in, sentence reports out.
module nmea_sentence_deframer_test;
    import nsd_pkg::*;

    localparam int unsigned LINE_BYTES    = 1024;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam logic [7:0]  CH_CR         = 8'h0D;

    // How the characters after the closing star are formed.
    typedef enum int {
        CK_UPPER,
        CK_LOWER,
        CK_ONE_DIGIT,
        CK_WRONG,
        CK_NON_DIGIT,
        CK_NONE
    } t_ck_style;

    typedef logic [7:0] t_bytes[$];

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    nmea_sentence_deframer #(
        .LINE_BUFFER_BYTES(LINE_BYTES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    // Stimulus bookkeeping.
    t_in_item    tx_items[$];
    t_out_item   expected_reports[$];
    int unsigned queued_count   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    bit          in_fire        = 1'b0;

    string       sentence_ids[8] = '{"GPRMC", "GNGGA", "GPGSA", "GPTXT",
                                     "GPGSV", "GPRM", "GPTXX", "BDGSA"};
    string       field_chars     = ",.0123456789ABCDEFNSEWabcf";
    logic [7:0]  non_digit[3]    = '{8'h47, 8'h2C, CH_CR};

    // Shadow of the line state and the strict setting.
    bit          strict_mode = 1'b0;
    int unsigned line_held;
    bit          in_frame;
    logic [7:0]  xor_run;
    logic [7:0]  xor_star;
    bit          star_found;
    int unsigned tail_bytes;
    logic [7:0]  hex_acc;
    bit          hex_end;
    logic [7:0]  id_head[5];
    int unsigned body_len;
    int unsigned body_star;

    function automatic void clear_line();
        line_held  = 0;
        in_frame   = 1'b0;
        xor_run    = '0;
        xor_star   = '0;
        star_found = 1'b0;
        tail_bytes = 0;
        hex_acc    = '0;
        hex_end    = 1'b0;
        foreach (id_head[i]) id_head[i] = '0;
        body_len   = 0;
        body_star  = 0;
    endfunction

    // The name must sit entirely inside the payload, starting at the given offset.
    function automatic bit id_at(int unsigned offset, logic [39:0] name, int unsigned len);
        if (body_star < offset + len) return 1'b0;
        for (int unsigned i = 0; i < len; i++) begin
            if (id_head[offset + i] != name[(len - 1 - i) * 8 +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] kind_of_line();
        if (id_at(2, 40'(ID_RMC), 3))  return KIND_RMC;
        if (id_at(2, 40'(ID_GGA), 3))  return KIND_GGA;
        if (id_at(2, 40'(ID_GSA), 3))  return KIND_GSA;
        if (id_at(0, ID_GPTXT, 5))     return KIND_GPTXT;
        if (id_at(0, 40'(ID_PROP), 4)) return KIND_PROPRIETARY;
        return KIND_UNKNOWN;
    endfunction

    function automatic int hex_value(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 8'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 8'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 8'h61 + 10;
        return -1;
    endfunction

    // Advance the shadow line state by one accepted item and queue any report it closes.
    function automatic void absorb_item(t_in_item it);
        t_out_item  rep;
        int         digit;
        logic [7:0] b;
        b = it.rx_byte;
        if (it.flush) begin
            clear_line();
            return;
        end
        if (b == CH_NEWLINE) begin
            if (in_frame && star_found && tail_bytes >= 1 &&
                (xor_star == hex_acc || !strict_mode)) begin
                rep.sentence_kind     = kind_of_line();
                rep.checksum_ok       = (xor_star == hex_acc);
                rep.computed_checksum = xor_star;
                rep.received_checksum = hex_acc;
                rep.payload_length    = (body_star > 1023) ? 10'd1023 : 10'(body_star);
                expected_reports.push_back(rep);
            end
            clear_line();
            return;
        end
        line_held++;
        if (line_held >= LINE_BYTES) begin
            clear_line();
            return;
        end
        if (!in_frame) begin
            if (b == CH_DOLLAR) begin
                in_frame   = 1'b1;
                xor_run    = '0;
                body_len   = 0;
                star_found = 1'b0;
            end
            return;
        end
        // Every star restarts the checksum field; only the last one counts.
        if (b == CH_STAR) begin
            star_found = 1'b1;
            xor_star   = xor_run;
            body_star  = body_len;
            tail_bytes = 0;
            hex_acc    = '0;
            hex_end    = 1'b0;
        end else if (star_found) begin
            if (tail_bytes < 2 && !hex_end) begin
                digit = hex_value(b);
                if (digit < 0) begin
                    hex_end = 1'b1;
                end else begin
                    hex_acc = {hex_acc[3:0], 4'(digit)};
                end
            end
            if (tail_bytes < 3) tail_bytes++;
        end
        if (body_len < 5) id_head[body_len] = b;
        xor_run ^= b;
        body_len++;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result checking first, then prediction for the item taken at this edge.
    always @(posedge clk) begin
        t_out_item want;
        in_fire = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result item %p", out_item);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("sentence_kind", 32'(want.sentence_kind),
                            32'(out_item.sentence_kind));
                check_field("checksum_ok", 32'(want.checksum_ok), 32'(out_item.checksum_ok));
                check_field("computed_checksum", 32'(want.computed_checksum),
                            32'(out_item.computed_checksum));
                check_field("received_checksum", 32'(want.received_checksum),
                            32'(out_item.received_checksum));
                check_field("payload_length", 32'(want.payload_length),
                            32'(out_item.payload_length));
            end
        end
        if (in_fire) absorb_item(in_item);
    end

    // Sender and receiver drive at the falling edge; a presented item holds until taken.
    always @(negedge clk) begin
        if (!in_valid || in_fire) begin
            if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= tx_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void queue_byte(logic [7:0] b);
        tx_items.push_back(t_in_item'{rx_byte: b, flush: 1'b0});
        queued_count++;
    endfunction

    function automatic void queue_flush();
        tx_items.push_back(t_in_item'{rx_byte: 8'($urandom_range(255)), flush: 1'b1});
        queued_count++;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic t_bytes text_bytes(string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Leading characters of the proprietary talker name, taken from the package.
    function automatic t_bytes prop_bytes(int unsigned n);
        t_bytes q;
        for (int unsigned i = 0; i < n; i++) q.push_back(ID_PROP[(3 - i) * 8 +: 8]);
        return q;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10) return 8'h30 + n;
        return 8'((lower ? 8'h61 : 8'h41) + n - 10);
    endfunction

    function automatic void queue_hex(logic [7:0] v, bit lower);
        queue_byte(hex_char(v[7:4], lower));
        queue_byte(hex_char(v[3:0], lower));
    endfunction

    // Dollar, payload, star and a checksum field in the requested form.
    function automatic void queue_sentence(t_bytes body, t_ck_style style);
        logic [7:0] sum;
        logic [7:0] bad;
        sum = '0;
        queue_byte(CH_DOLLAR);
        foreach (body[i]) begin
            queue_byte(body[i]);
            sum ^= body[i];
        end
        queue_byte(CH_STAR);
        case (style)
            CK_UPPER:     queue_hex(sum, 1'b0);
            CK_LOWER:     queue_hex(sum, 1'b1);
            CK_ONE_DIGIT: queue_byte(hex_char(sum[3:0], 1'($urandom_range(1))));
            CK_WRONG: begin
                bad = sum ^ 8'($urandom_range(1, 255));
                queue_hex(bad, 1'b0);
            end
            CK_NON_DIGIT: queue_byte(non_digit[$urandom_range(2)]);
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] rand_body_char();
        int r;
        r = $urandom_range(99);
        if (r < 85) return field_chars[$urandom_range(field_chars.len() - 1)];
        if (r < 95) return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    function automatic t_bytes rand_payload();
        t_bytes q;
        int     r;
        r = $urandom_range(11);
        if (r < 8) begin
            q = text_bytes(sentence_ids[r]);
        end else if (r == 8) begin
            q = prop_bytes(4);
        end else if (r == 9) begin
            q = prop_bytes(3);
        end else if (r == 11) begin
            repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        repeat ($urandom_range(0, 20)) q.push_back(rand_body_char());
        return q;
    endfunction

    function automatic t_ck_style rand_style();
        int r;
        r = $urandom_range(99);
        if (r < 55) return CK_UPPER;
        if (r < 65) return CK_LOWER;
        if (r < 73) return CK_ONE_DIGIT;
        if (r < 85) return CK_WRONG;
        if (r < 93) return CK_NON_DIGIT;
        return CK_NONE;
    endfunction

    // Mostly well-formed sentences with random content; some noise and cut-off lines.
    function automatic void queue_random_line();
        t_bytes body;
        int     r;
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(255)));
            if ($urandom_range(1)) queue_byte(CH_NEWLINE);
        end else if (r < 15) begin
            queue_byte(CH_DOLLAR);
            repeat ($urandom_range(0, 8)) queue_byte(rand_body_char());
            if ($urandom_range(1)) queue_text("*4");
            queue_flush();
        end else begin
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(1, 3)) queue_byte($urandom_range(1) ? CH_STAR : 8'h41);
            end
            body = rand_payload();
            queue_sentence(body, rand_style());
            if ($urandom_range(99) < 30) queue_byte(CH_CR);
            if ($urandom_range(99) < 5) queue_byte(8'h37);
            r = $urandom_range(99);
            if (r < 93) begin
                queue_byte(CH_NEWLINE);
            end else if (r < 97) begin
                queue_flush();
            end
        end
    endfunction

    // A line at the buffer limit: either its newline is the last byte that still fits,
    // or one byte too many drops the line and the rest is collected as a new line.
    function automatic void queue_long_line(bit overflow);
        queue_flush();
        queue_byte(CH_DOLLAR);
        repeat (LINE_BYTES - (overflow ? 3 : 4)) queue_byte(8'($urandom_range(8'h41, 8'h5A)));
        queue_byte(CH_STAR);
        queue_byte(8'h35);
        queue_byte(CH_NEWLINE);
        if (overflow) begin
            queue_text("7*3");
            queue_byte(CH_NEWLINE);
        end
    endfunction

    task automatic write_strict(bit value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_STRICT_CHECKSUM * 4);
        pwdata  <= {31'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        strict_mode = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The register reads back what was written.
        check_field("strict_checksum", 32'(value), prdata);
    endtask

    task automatic wait_drained();
        while (tx_items.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset, a directed pass over the special cases, then random phases.
    initial begin
        int unsigned target;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        write_strict(1'b0);

        queue_sentence(text_bytes("GPRMC,1"), CK_UPPER);
        queue_byte(CH_CR);
        queue_byte(CH_NEWLINE);
        queue_sentence(text_bytes("GNGGA,2"), CK_LOWER);
        queue_byte(CH_NEWLINE);
        queue_sentence(text_bytes("GPGSA"), CK_ONE_DIGIT);
        queue_byte(CH_NEWLINE);
        queue_sentence(text_bytes("GPTXT,01"), CK_UPPER);
        queue_byte(CH_NEWLINE);
        queue_sentence(prop_bytes(4), CK_WRONG);
        queue_byte(CH_NEWLINE);
        // Stars only ahead of the dollar give no report.
        queue_text("*12$GPGSV");
        queue_byte(CH_NEWLINE);
        // Star with nothing after it, then star followed by a non-digit.
        queue_sentence(text_bytes("AB"), CK_NONE);
        queue_byte(CH_NEWLINE);
        queue_sentence(text_bytes("AB"), CK_NON_DIGIT);
        queue_byte(CH_NEWLINE);
        // Empty payload, and names cut short by the star.
        queue_sentence(text_bytes(""), CK_UPPER);
        queue_byte(CH_NEWLINE);
        queue_sentence(text_bytes("GPRM"), CK_UPPER);
        queue_byte(CH_NEWLINE);
        // Flush in the middle of a sentence.
        queue_text("$GPRMC");
        queue_flush();
        queue_text("*00");
        queue_byte(CH_NEWLINE);
        // Several stars, a second dollar, and a third checksum digit.
        queue_sentence(text_bytes("A*B"), CK_UPPER);
        queue_byte(CH_NEWLINE);
        queue_sentence(text_bytes("$A"), CK_UPPER);
        queue_text("3");
        queue_byte(CH_NEWLINE);
        queue_text("NO*12");
        queue_byte(CH_NEWLINE);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            write_strict(1'(p % 2));
            case (p / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (p == 2) queue_long_line(1'b1);
            target = queued_count + 90;
            while (queued_count < target) queue_random_line();
        end

        wait_drained();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Give up if the run stops making progress.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
